[hdl/vwbp_pkg.sv]
// Shared constants and types for the variable width bit packer.
// Used by vwbp_pack, vwbp_frame_queue and variable_width_bit_packer_core.
// No dependencies.
`default_nettype none

package vwbp_pkg;

  localparam int BUFFER_BYTES = 32;
  localparam int WORD_W       = 64;
  localparam int WIDTH_W      = 7;
  localparam int NUM_WORDS    = (BUFFER_BYTES + 7) / 8;
  localparam int BUF_W        = NUM_WORDS * WORD_W;
  localparam int CAP_BITS     = BUFFER_BYTES * 8;
  localparam int FILL_W       = $clog2(CAP_BITS);
  localparam int SUM_W        = $clog2(CAP_BITS + WORD_W + 1);
  localparam int WIDX_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_TDATA_W   = ((WORD_W + WIDTH_W + 7) / 8) * 8;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_FLUSH = 1'b1
  } action_t;

  // One completed buffer handed from the packer to the output queue.
  typedef struct packed {
    logic             valid;
    logic [BUF_W-1:0] data;
  } frame_push_t;

endpackage

`default_nettype wire

[hdl/vwbp_pack.sv]
// Packing datapath: holds the wide pack buffer and fill count, appends fields
// and produces completed frames. Depends on vwbp_pkg.
`default_nettype none

module vwbp_pack (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_acc,
  input  wire                                 action,
  input  wire  [vwbp_pkg::WORD_W-1:0]         field_value,
  input  wire  [vwbp_pkg::WIDTH_W-1:0]        field_width,
  output vwbp_pkg::frame_push_t               push
);

  localparam int BUF_W  = vwbp_pkg::BUF_W;
  localparam int WORD_W = vwbp_pkg::WORD_W;
  localparam int FILL_W = vwbp_pkg::FILL_W;
  localparam int SUM_W  = vwbp_pkg::SUM_W;
  localparam int WID_W  = vwbp_pkg::WIDTH_W;

  logic [BUF_W-1:0]  buf_r,  buf_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic [WID_W-1:0]  w_cl;
  logic [WORD_W-1:0] v_m;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  room;
  logic              wr_full;
  logic [WID_W-1:0]  t_sh;
  logic [WID_W-1:0]  r_low;
  logic [5:0]        pad;
  logic [WID_W-1:0]  shamt;
  logic [WORD_W-1:0] ins;
  logic [BUF_W-1:0]  shifted;
  logic              emit;

  function automatic logic [WORD_W-1:0] low_mask(input logic [WID_W-1:0] n);
    logic [WORD_W-1:0] m;
    if (n >= WID_W'(WORD_W)) begin
      m = '1;
    end else begin
      m = (WORD_W'(1) << n) - WORD_W'(1);
    end
    return m;
  endfunction

  assign w_cl    = (field_width > WID_W'(WORD_W)) ? WID_W'(WORD_W) : field_width;
  assign v_m     = field_value & low_mask(w_cl);
  assign sum     = SUM_W'(fill_r) + SUM_W'(w_cl);
  assign room    = SUM_W'(vwbp_pkg::CAP_BITS) - SUM_W'(fill_r);
  assign wr_full = (sum >= SUM_W'(vwbp_pkg::CAP_BITS));
  // room is 1..64 whenever the field reaches capacity
  assign t_sh    = room[WID_W-1:0];
  assign r_low   = w_cl - t_sh;
  assign pad     = room[5:0];

  // pick shift amount and inserted bits for the single buffer shifter
  always_comb begin
    shamt = w_cl;
    ins   = v_m;
    if (action == vwbp_pkg::ACT_FLUSH) begin
      shamt = {1'b0, pad};
      ins   = '0;
    end else if (wr_full) begin
      shamt = t_sh;
      ins   = v_m >> r_low;
    end
  end

  assign shifted = (buf_r << shamt) | BUF_W'(ins);

  always_comb begin
    buf_nxt  = buf_r;
    fill_nxt = fill_r;
    emit     = 1'b0;
    if (in_acc) begin
      if (action == vwbp_pkg::ACT_FLUSH) begin
        if (fill_r != '0) begin
          emit     = 1'b1;
          buf_nxt  = '0;
          fill_nxt = '0;
        end
      end else if (w_cl != '0) begin
        if (wr_full) begin
          // low bits of a split field start the next buffer
          emit     = 1'b1;
          buf_nxt  = BUF_W'(v_m & low_mask(r_low));
          fill_nxt = FILL_W'(r_low);
        end else begin
          buf_nxt  = shifted;
          fill_nxt = FILL_W'(sum);
        end
      end
    end
  end

  assign push.valid = emit;
  assign push.data  = shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      fill_r <= '0;
    end else begin
      buf_r  <= buf_nxt;
      fill_r <= fill_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) < vwbp_pkg::CAP_BITS)
    else $error("fill count reached capacity");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && action == vwbp_pkg::ACT_FLUSH && fill_r != '0) |=> (fill_r == '0))
    else $error("flush did not clear fill count");

  a_write_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && action == vwbp_pkg::ACT_WRITE && w_cl != '0 && !wr_full)
      |=> (fill_r != '0))
    else $error("partial write left buffer empty");
`endif

endmodule

`default_nettype wire

[hdl/vwbp_frame_queue.sv]
// Output queue of completed frames and word serializer, least significant
// word first. Depends on vwbp_pkg.
`default_nettype none

module vwbp_frame_queue (
  input  wire                             clk,
  input  wire                             rst_n,
  input  vwbp_pkg::frame_push_t           push,
  output logic                            space,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [vwbp_pkg::WORD_W-1:0]     out_tdata,
  output logic                            out_tlast
);

  localparam int DEPTH  = vwbp_pkg::QUEUE_DEPTH;
  localparam int PTR_W  = vwbp_pkg::PTR_W;
  localparam int CNT_W  = vwbp_pkg::CNT_W;
  localparam int WIDX_W = vwbp_pkg::WIDX_W;
  localparam int WORD_W = vwbp_pkg::WORD_W;

  logic [vwbp_pkg::BUF_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [WIDX_W-1:0] widx_r,   widx_nxt;
  logic              pop_word;
  logic              pop_frame;

  assign space      = (cnt_r != CNT_W'(DEPTH));
  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = (widx_r == WIDX_W'(vwbp_pkg::NUM_WORDS - 1));
  assign out_tdata  = mem_r[rd_ptr_r][int'(widx_r) * WORD_W +: WORD_W];
  assign pop_word   = out_tvalid && out_tready;
  assign pop_frame  = pop_word && out_tlast;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    widx_nxt   = widx_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_word) begin
      if (out_tlast) begin
        widx_nxt   = '0;
        rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end else begin
        widx_nxt = widx_r + WIDX_W'(1);
      end
    end
    if (push.valid && !pop_frame) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push.valid && pop_frame) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      widx_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      widx_r   <= widx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= DEPTH)
    else $error("frame queue count overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (cnt_r != CNT_W'(DEPTH)))
    else $error("frame pushed into full queue");

  a_idle_word_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (widx_r == '0))
    else $error("word index moved with empty queue");
`endif

endmodule

`default_nettype wire

[hdl/variable_width_bit_packer_core.sv]
// Top level of the variable width bit packer: stream ports, packing datapath
// and frame output queue. Depends on vwbp_pkg, vwbp_pack, vwbp_frame_queue.
`default_nettype none

// Packs fields of 1 to 64 bits into a 256-bit buffer (BUFFER_BYTES = 32) that
// behaves as one wide integer; each field shifts the buffer left and lands in
// the low bits. A full buffer, or a flush of a non-empty one padded to a 64-bit
// boundary, is emitted as four 64-bit words, least significant first, with
// tlast on the fourth. One input transaction is taken per cycle while
// in_tready is high, and its effect on the buffer is complete in that cycle.
// Emitted buffers wait in a two-frame queue and leave at one word per cycle
// while out_tready is high; in_tready drops only while both slots are occupied.
module variable_width_bit_packer_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // [63:0] field_value, [70:64] field_width, [71] zero
  input  wire  [vwbp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] action
  input  wire                                in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [63:0] out_word
  output logic [vwbp_pkg::WORD_W-1:0]        out_tdata,
  // last_word
  output logic                               out_tlast
);

  localparam int WORD_W = vwbp_pkg::WORD_W;
  localparam int WID_W  = vwbp_pkg::WIDTH_W;

  vwbp_pkg::frame_push_t push;
  logic                  space;
  logic                  in_acc;

  assign in_tready = space;
  assign in_acc    = in_tvalid && in_tready;

  vwbp_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .action      (in_tuser),
    .field_value (in_tdata[WORD_W-1:0]),
    .field_width (in_tdata[WORD_W+WID_W-1:WORD_W]),
    .push        (push)
  );

  vwbp_frame_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
